FILE: design/signed_int_to_decimal_ascii_macros.svh
// Assertion macros shared by the signed integer to decimal text block.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH

// Same-cycle implication, checked on clk outside reset.
`define SITDA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on clk outside reset.
`define SITDA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/sitda_pkg.sv
// Shared types and constants of the signed integer to decimal text block.
package sitda_pkg;

    localparam int STEP_BITS = 2;
    localparam int DIGIT_W   = 4;
    localparam int CHAR_W    = 6;

    typedef logic [DIGIT_W-1:0] digit_t;
    typedef logic [CHAR_W-1:0]  char_t;

    localparam digit_t ADJ_THRESHOLD = 4'd5;
    localparam digit_t ADJ_OFFSET    = 4'd3;

    localparam char_t CH_ZERO  = 6'd48;
    localparam char_t CH_MINUS = 6'd45;
    localparam char_t CH_NINE  = 6'd57;

endpackage

FILE: design/signed_int_to_decimal_ascii.sv
// Signed integer to decimal ASCII text, one character per output beat.
// An item holds the block (item_stall high) from acceptance until its last character is loaded,
// output stalls included, so no new value is taken before then.
// The first character leaves later for shorter numbers, which have more leading zero digits to skip.
// The rate is set by the shift/add-3 unit (two bits per pass) and one character per unstalled cycle out.
// Reset (rst_n low, asynchronous) returns the sequencer to idle and empties the output register.
module signed_int_to_decimal_ascii #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic signed [VALUE_WIDTH-1:0] value,
    output logic                          text_valid,
    input  logic                          text_stall,
    output sitda_pkg::char_t              character,
    output logic                          last
);
    import sitda_pkg::*;

    // Magnitude width padded to a whole number of bits per pass.
    localparam int MAG_W      = VALUE_WIDTH + (VALUE_WIDTH % STEP_BITS);
    localparam int STEPS      = MAG_W / STEP_BITS;
    // Enough digits for 2^(VALUE_WIDTH-1) at the default width, though not at every width.
    localparam int NUM_DIGITS = (VALUE_WIDTH * 3) / 10 + 1;
    localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
    localparam int CNT_MAX    = (STEPS > NUM_DIGITS) ? STEPS - 1 : NUM_DIGITS - 1;
    localparam int CNT_W      = $clog2(CNT_MAX + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_EMIT
    } state_t;

    state_t           state_reg, state_next;
    logic             neg_reg, neg_next;
    logic [MAG_W-1:0] mag_reg, mag_next;
    logic [BCD_W-1:0] bcd_reg, bcd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             text_valid_reg, text_valid_next;
    char_t            character_reg, character_next;
    logic             last_reg, last_next;

    logic [VALUE_WIDTH-1:0] value_bits;
    logic [VALUE_WIDTH-1:0] abs_value;
    logic [BCD_W-1:0]       step_bcd;
    digit_t                 top_digit;
    logic                   out_free;

    // Two's complement magnitude; the most negative value maps to 2^(VALUE_WIDTH-1).
    assign value_bits = value;
    assign abs_value  = value_bits[VALUE_WIDTH-1] ? (VALUE_WIDTH'(0) - value_bits) : value_bits;

    assign top_digit = bcd_reg[BCD_W-1 -: DIGIT_W];

    // The output register may load when empty or when its beat leaves this cycle.
    assign out_free = !text_valid_reg || !text_stall;

    // Shared conversion unit: consumes the top STEP_BITS of the magnitude each pass.
    sitda_bcd_step #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_bcd_step (
        .bcd_in  (bcd_reg),
        .bits_in (mag_reg[MAG_W-1 -: STEP_BITS]),
        .bcd_out (step_bcd)
    );

    always_comb
    begin
        state_next      = state_reg;
        neg_next        = neg_reg;
        mag_next        = mag_reg;
        bcd_next        = bcd_reg;
        cnt_next        = cnt_reg;
        // drop the held beat once it is taken
        text_valid_next = text_valid_reg && text_stall;
        character_next  = character_reg;
        last_next       = last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    neg_next   = value_bits[VALUE_WIDTH-1];
                    mag_next   = MAG_W'(abs_value);
                    bcd_next   = '0;
                    cnt_next   = CNT_W'(STEPS - 1);
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                // advance the binary word through the shift/add-3 unit
                bcd_next = step_bcd;
                mag_next = mag_reg << STEP_BITS;
                if (cnt_reg == '0)
                begin
                    cnt_next   = CNT_W'(NUM_DIGITS - 1);
                    state_next = ST_SKIP;
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            ST_SKIP:
            begin
                // drop leading zero digits, but always keep the units digit
                if (top_digit == '0 && cnt_reg != '0)
                begin
                    bcd_next = bcd_reg << DIGIT_W;
                    cnt_next = cnt_reg - CNT_W'(1);
                end
                else
                begin
                    state_next = neg_reg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    text_valid_next = 1'b1;
                    character_next  = CH_MINUS;
                    last_next       = 1'b0;
                    state_next      = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    text_valid_next = 1'b1;
                    character_next  = CH_ZERO + CHAR_W'(top_digit);
                    last_next       = (cnt_reg == '0);
                    bcd_next        = bcd_reg << DIGIT_W;
                    if (cnt_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg - CNT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            neg_reg        <= 1'b0;
            mag_reg        <= '0;
            bcd_reg        <= '0;
            cnt_reg        <= '0;
            text_valid_reg <= 1'b0;
            character_reg  <= CH_ZERO;
            last_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            neg_reg        <= neg_next;
            mag_reg        <= mag_next;
            bcd_reg        <= bcd_next;
            cnt_reg        <= cnt_next;
            text_valid_reg <= text_valid_next;
            character_reg  <= character_next;
            last_reg       <= last_next;
        end
    end

    assign item_stall = (state_reg != ST_IDLE);
    assign text_valid = text_valid_reg;
    assign character  = character_reg;
    assign last       = last_reg;

`include "signed_int_to_decimal_ascii_macros.svh"

    `SITDA_ASSERT_NOW(a_char_range, text_valid,
        (character == CH_MINUS) || ((character >= CH_ZERO) && (character <= CH_NINE)),
        "character outside minus sign and digit codes")

    `SITDA_ASSERT_NOW(a_sign_not_last, text_valid && (character == CH_MINUS), !last,
        "minus sign marked as last character")

    `SITDA_ASSERT_NEXT(a_last_ends_item,
        (state_reg == ST_EMIT) && out_free && (cnt_reg == '0),
        (state_reg == ST_IDLE) && text_valid && last,
        "final digit did not close the item")

endmodule

FILE: design/sitda_bcd_step.sv
// Shift and add-3 unit: folds STEP_BITS binary bits into a packed BCD word.
module sitda_bcd_step #(
    parameter int NUM_DIGITS = 10
) (
    input  logic [NUM_DIGITS*sitda_pkg::DIGIT_W-1:0] bcd_in,
    input  logic [sitda_pkg::STEP_BITS-1:0]          bits_in,
    output logic [NUM_DIGITS*sitda_pkg::DIGIT_W-1:0] bcd_out
);
    import sitda_pkg::*;

    localparam int BCD_W = NUM_DIGITS * DIGIT_W;

    logic [BCD_W-1:0] work;

    always_comb
    begin
        work = bcd_in;
        for (int s = 0; s < STEP_BITS; s++)
        begin
            // adjust every digit that would overflow on doubling
            for (int d = 0; d < NUM_DIGITS; d++)
            begin
                if (work[d*DIGIT_W +: DIGIT_W] >= ADJ_THRESHOLD)
                begin
                    work[d*DIGIT_W +: DIGIT_W] = work[d*DIGIT_W +: DIGIT_W] + ADJ_OFFSET;
                end
            end
            // shift in the next binary bit, most significant first
            work = {work[BCD_W-2:0], bits_in[STEP_BITS-1-s]};
        end
        bcd_out = work;
    end

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the signed integer to decimal ASCII text block.

localparam int unsigned DEC_RADIX = 10;

// One output beat: a character and its end-of-number mark.
typedef struct packed {
    sitda_pkg::char_t ch;
    logic             last;
} text_beat_t;

class ascii_text_scoreboard;
    text_beat_t  expected_text[$];
    int unsigned errors;

    // Turn one accepted value into the characters it must produce.
    function void queue_decimal_text(input logic signed [31:0] v);
        logic [31:0]      mag;
        logic             neg;
        sitda_pkg::char_t digits[$];
        text_beat_t       beat;
        neg = v[31];
        mag = v;
        if (neg)
            mag = ~mag + 32'd1;
        if (mag == 0)
            digits.push_front(sitda_pkg::CH_ZERO);
        while (mag != 0)
        begin
            digits.push_front(sitda_pkg::CH_ZERO + sitda_pkg::char_t'(mag % DEC_RADIX));
            mag = mag / DEC_RADIX;
        end
        if (neg)
        begin
            beat.ch   = sitda_pkg::CH_MINUS;
            beat.last = 1'b0;
            expected_text.push_back(beat);
        end
        foreach (digits[i])
        begin
            beat.ch   = digits[i];
            beat.last = (i == digits.size() - 1);
            expected_text.push_back(beat);
        end
    endfunction

    task report(input string msg);
        errors++;
        $display("%s", msg);
    endtask

    // Compare one accepted character beat with the oldest expectation.
    task check_char(input sitda_pkg::char_t ch, input logic last);
        text_beat_t want;
        if (expected_text.size() == 0)
        begin
            report($sformatf("unexpected beat: char %0d last %0b", ch, last));
            return;
        end
        want = expected_text.pop_front();
        if (ch !== want.ch)
            report($sformatf("char mismatch: got %0d, want %0d", ch, want.ch));
        if (last !== want.last)
            report($sformatf("last mismatch on char %0d: got %0b, want %0b",
                             want.ch, last, want.last));
    endtask

    function int unsigned pending();
        return expected_text.size();
    endfunction
endclass

module tb_top;
    import sitda_pkg::*;

    localparam int          VW             = 32;
    localparam int          RESET_CYCLES   = 11;
    localparam int          IDLE_PERCENT   = 30;
    localparam int          MAX_GAP        = 60;
    localparam int          RANDOM_ITEMS   = 120;
    localparam int          CALM_ITEMS     = 40;
    localparam int          TAIL_CYCLES    = 40;
    localparam int unsigned WATCHDOG_LIMIT = 2000;

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 item_valid = 1'b0;
    logic                 item_stall;
    logic signed [VW-1:0] value      = '0;
    logic                 text_valid;
    logic                 text_stall = 1'b0;
    char_t                character;
    logic                 last;

    // item_fire and text_fire are computed at the falling edge and consumed at the next rising edge.
    logic        item_fire   = 1'b0;
    logic        text_fire   = 1'b0;
    logic        calm        = 1'b0;
    int unsigned idle_cycles = 0;

    ascii_text_scoreboard text_sb;

    signed_int_to_decimal_ascii #(
        .VALUE_WIDTH(VW)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .value     (value),
        .text_valid(text_valid),
        .text_stall(text_stall),
        .character (character),
        .last      (last)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Inputs and outputs only move at the rising edge, so everything seen at
    // the falling edge holds until the next rising edge: decide acceptance
    // of both channels here, note the input beat and check the output beat.
    always @(negedge clk)
    begin
        item_fire = rst_n && item_valid && !item_stall;
        text_fire = rst_n && text_valid && !text_stall;
        if (item_fire)
            text_sb.queue_decimal_text(value);
        if (text_fire)
            text_sb.check_char(character, last);
    end

    // Stall the text channel in roughly 30 percent of cycles, except in
    // the calm stretch.
    always @(posedge clk)
        text_stall <= !calm && ($urandom_range(0, 99) < IDLE_PERCENT);

    // Count cycles with no beat on either channel; give up past the limit.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_fire || text_fire)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Offer one value. Enter and leave at a rising edge; drop valid only
    // when a gap is taken, so valid never falls and rises in the same step.
    // A gap may outlast the conversion, so the block also sits idle with
    // nothing offered.
    task automatic send_value(input logic signed [VW-1:0] v);
        int unsigned gap;
        gap = 0;
        if (!calm && ($urandom_range(0, 99) < IDLE_PERCENT))
            gap = $urandom_range(1, MAX_GAP);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        value      <= v;
        do
            @(posedge clk);
        while (!item_fire);
    endtask

    // Hold the input side idle until every expected character has come.
    task automatic hold_until_drained();
        item_valid <= 1'b0;
        while (text_sb.pending() != 0)
            @(posedge clk);
    endtask

    // Mix full-range words with short numbers, numbers of at most a chosen digit
    // count and values on either side of a power of ten, either sign.
    function automatic logic signed [VW-1:0] random_value();
        logic [VW-1:0] mag;
        int unsigned   ndig;
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: mag = $urandom_range(0, 999);
            2:
            begin
                ndig = $urandom_range(1, 9);
                mag  = $urandom_range(0, (32'd10 ** ndig) - 1);
            end
            default: mag = (32'd10 ** $urandom_range(0, 9)) - $urandom_range(0, 1);
        endcase
        if ($urandom_range(0, 1) != 0)
            mag = ~mag + 1'b1;
        return mag;
    endfunction

    initial
    begin
        logic signed [VW-1:0] directed_values[$];

        text_sb = new();

        // Zero, single digits, digit-count boundaries, both extremes and
        // the most negative value whose magnitude does not fit as positive.
        directed_values = '{
            32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, -32'sd10,
            32'sd99, 32'sd100, 32'sd999999999, 32'sd1000000000,
            -32'sd1000000000, 32'sd123456789, 32'sd2147483647,
            -32'sd2147483647, 32'h8000_0000, 32'sh5555_5555, 32'shAAAA_AAAA
        };

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        foreach (directed_values[i])
            send_value(directed_values[i]);

        // Let the block drain completely once before the random part.
        hold_until_drained();

        // Run the first stretch of random items with no idling on either side.
        calm <= 1'b1;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == CALM_ITEMS)
                calm <= 1'b0;
            send_value(random_value());
        end

        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (text_sb.errors == 0 && text_sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

FILE: sim.f
+incdir+design
design/sitda_pkg.sv
design/sitda_bcd_step.sv
design/signed_int_to_decimal_ascii.sv
tb/sv/tb_top.sv
